[rtl/core/wads3_pkg.sv]
// shared types, register indexes and reset values for the 3x3 window
// absolute-difference sum block; depends on nothing
package wads3_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT    = 4096;

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 13;

   localparam logic [CSR_AW-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_AW-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_AW-1:0] REG_BORDER       = 2'd2;

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int BORDER_RESET = 1;

   localparam int RSP_DW = 40;

   // registered line store read word
   typedef struct packed {
      logic [7:0] upper;
      logic [7:0] lower;
   } ls_rd_type;

   typedef logic [8:0][7:0] window_type;

   // sum of |neighbor - center| over the eight neighbors, center in cell 4
   function automatic logic [10:0] abs_diff_sum(input window_type win);
      logic [10:0] sum;
      logic [7:0]  diff;
      sum = '0;
      for (int k = 0; k < 9; k++) begin
         if (k != 4) begin
            diff = (win[k] > win[4]) ? (win[k] - win[4]) : (win[4] - win[k]);
            sum  = sum + 11'(diff);
         end
      end
      return sum;
   endfunction

endpackage

[rtl/core/window_abs_diff_sum_3x3.sv]
// an accepted pixel word passes the window and output registers before its result is valid
// throughput: one pixel per cycle, set by the single line store port pair, while results are
// not stalled and no clearing pass runs; results come only for interior centers, and border
// pixels give no word; reset: synchronous; then a clearing pass zeroes every line store
// address, req_tready stays low during it while csr writes are taken
module window_abs_diff_sum_3x3 #(
   parameter int MAX_WIDTH = wads3_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] pixel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [10:0] response, [22:11] row, [32:23] col, [39:33] zero
   output logic [wads3_pkg::RSP_DW-1:0]   rsp_tdata,
   input  logic                           csr_we,
   input  logic [wads3_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [wads3_pkg::CSR_DW-1:0]   csr_wdata
);
   import wads3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int XW = WW + 5;
   localparam int HW = 14;

   // configuration, kept as effective values
   logic [WW-1:0] width_ff;
   logic [12:0]   height_ff;
   logic [3:0]    border_ff;
   logic [10:0]   wv;
   logic [12:0]   hv;
   logic [3:0]    bv;

   logic [AW-1:0] col_ff, col_in;
   logic [11:0]   row_ff, row_in;

   window_type    win_ff, win_in;
   logic          s1_valid_ff, s1_valid_in;
   logic [11:0]   s1_row_ff;
   logic [9:0]    s1_col_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [10:0]   resp_ff;
   logic [11:0]   row_out_ff;
   logic [9:0]    col_out_ff;

   ls_rd_type     ls_rd;
   logic          ls_busy;
   logic [AW-1:0] raddr;

   logic          accept, advance, has_result, col_last, row_last;
   logic [AW-1:0] col_m1;

   wads3_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
      .clock  (clock),
      .reset  (reset),
      .we     (accept),
      .waddr  (col_ff),
      .wpixel (req_tdata),
      .raddr  (raddr),
      .rd     (ls_rd),
      .busy   (ls_busy)
   );

   always_comb begin
      wv = csr_wdata[10:0];
      hv = csr_wdata[12:0];
      bv = csr_wdata[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(WIDTH_RESET);
         height_ff <= 13'(HEIGHT_RESET);
         border_ff <= 4'(BORDER_RESET);
      end else if (csr_we) begin
         case (csr_addr)
            REG_IMAGE_WIDTH: begin
               if (wv == 11'd0) width_ff <= WW'(1);
               else if (32'(wv) > MAX_WIDTH) width_ff <= WW'(MAX_WIDTH);
               else width_ff <= WW'(wv);
            end
            REG_IMAGE_HEIGHT: begin
               if (hv == 13'd0) height_ff <= 13'd1;
               else if (32'(hv) > MAX_HEIGHT) height_ff <= 13'(MAX_HEIGHT);
               else height_ff <= hv;
            end
            REG_BORDER: begin
               border_ff <= (bv == 4'd0) ? 4'd1 : bv;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      advance    = !rsp_valid_ff || rsp_tready;
      req_tready = !ls_busy && (!s1_valid_ff || advance);
      accept     = req_tvalid && req_tready;

      // the window's bottom right cell is at (row, col); its center one row and one column back
      has_result = (XW'(col_ff) >= XW'(border_ff) + XW'(1))
                && (XW'(col_ff) + XW'(border_ff) <= XW'(width_ff))
                && (HW'(row_ff) >= HW'(border_ff) + HW'(1))
                && (HW'(row_ff) + HW'(border_ff) <= HW'(height_ff));

      col_last = (XW'(col_ff) + XW'(1) >= XW'(width_ff));
      row_last = (HW'(row_ff) + HW'(1) >= HW'(height_ff));
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? 12'd0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      // read ahead at the position of the next word
      raddr  = col_in;
      col_m1 = col_ff - 1'b1;

      win_in = win_ff;
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]   = win_ff[k*3+1];
         win_in[k*3+1] = win_ff[k*3+2];
      end
      win_in[2] = ls_rd.upper;
      win_in[5] = ls_rd.lower;
      win_in[8] = req_tdata;

      if (accept) s1_valid_in = has_result;
      else if (advance) s1_valid_in = 1'b0;
      else s1_valid_in = s1_valid_ff;

      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         win_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff <= row_ff - 12'd1;
         s1_col_ff <= 10'(col_m1);
      end
      if (advance && s1_valid_ff) begin
         resp_ff    <= abs_diff_sum(win_ff);
         row_out_ff <= s1_row_ff;
         col_out_ff <= s1_col_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, col_out_ff, row_out_ff, resp_ff};

endmodule

[rtl/core/wads3_line_store.sv]
// two line stores with registered write-first read and a clearing pass
// after reset; depends on wads3_pkg
module wads3_line_store #(
   parameter int MAX_WIDTH = wads3_pkg::MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         we,
   input  logic [$clog2(MAX_WIDTH)-1:0] waddr,
   input  logic [7:0]                   wpixel,
   input  logic [$clog2(MAX_WIDTH)-1:0] raddr,
   output wads3_pkg::ls_rd_type         rd,
   output logic                         busy
);
   import wads3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic [7:0] upper_mem [MAX_WIDTH];
   logic [7:0] lower_mem [MAX_WIDTH];

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          busy_ff, busy_in;
   ls_rd_type     rd_ff;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   ls_rd_type     mem_wd;

   always_comb begin
      mem_we = busy_ff | we;
      mem_wa = busy_ff ? clr_addr_ff : waddr;
      // the upper row takes what the lower row held at this column
      mem_wd.upper = busy_ff ? 8'd0 : rd_ff.lower;
      mem_wd.lower = busy_ff ? 8'd0 : wpixel;
      clr_addr_in  = clr_addr_ff + 1'b1;
      busy_in      = busy_ff && (clr_addr_ff != AW'(MAX_WIDTH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         upper_mem[mem_wa] <= mem_wd.upper;
         lower_mem[mem_wa] <= mem_wd.lower;
      end
      if (mem_we && mem_wa == raddr) begin
         rd_ff <= mem_wd;
      end else begin
         rd_ff.upper <= upper_mem[raddr];
         rd_ff.lower <= lower_mem[raddr];
      end
   end

   assign rd   = rd_ff;
   assign busy = busy_ff;

endmodule

[rtl/core/wads3_check.sv]
// port-level checks for window_abs_diff_sum_3x3, bound to the top level;
// depends on wads3_pkg
module wads3_check (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [wads3_pkg::RSP_DW-1:0]   rsp_tdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // clearing pass blocks input right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input taken during line store clearing");

   // eight differences of at most 255 each
   a_resp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:0] <= 11'd2040)
      else $error("response out of range");

   // interior centers are never on row zero, padding stays zero
   a_row_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:11] != 12'd0 && rsp_tdata[39:33] == 7'd0)
      else $error("bad row or padding in result word");

   // every new result comes from an input word that passed through the window and output registers
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without matching input word");

endmodule

bind window_abs_diff_sum_3x3 wads3_check u_wads3_check (.*);

[test/tb_window_abs_diff_sum_3x3.sv]
`timescale 1ns / 100ps
// bench for window_abs_diff_sum_3x3: streams pixel words, keeps its own window model
// and checks every result word against it; depends on wads3_pkg and the block itself
module tb_window_abs_diff_sum_3x3;
   import wads3_pkg::*;

   localparam int LINE_MAX     = MAX_WIDTH_DEF;
   localparam int CYCLE_LIMIT  = 1_200_000;
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int WIDE_ROW     = 256;
   localparam int RANDOM_ITEMS = 480;

   typedef struct packed {
      logic [6:0]  pad;
      logic [9:0]  col;
      logic [11:0] row;
      logic [10:0] response;
   } window_result_type;

   typedef enum int { PIX_UNIFORM, PIX_EXTREME, PIX_SMOOTH, PIX_FLAT } pixel_style_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;   // [7:0] pixel
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // [10:0] response, [22:11] row, [32:23] col, [39:33] zero
   logic [RSP_DW-1:0] rsp_tdata;
   logic              csr_we     = 1'b0;
   logic [CSR_AW-1:0] csr_addr   = '0;
   logic [CSR_DW-1:0] csr_wdata  = '0;

   // window model state
   logic [7:0]     upper_line [LINE_MAX];
   logic [7:0]     lower_line [LINE_MAX];
   logic [7:0]     win_cells [9];
   int unsigned    col_pos, row_pos;
   logic [10:0]    width_reg;
   logic [12:0]    height_reg;
   logic [3:0]     border_reg;

   window_result_type sums_due [$];
   logic [7:0]     pixels_waiting [$];
   int unsigned    pixels_queued = 0;
   int unsigned    pixels_taken  = 0;
   int unsigned    words_seen    = 0;
   int unsigned    failures      = 0;
   int unsigned    cycles        = 0;
   int unsigned    send_gap      = 0;
   int unsigned    stall_left    = 0;
   bit             send_burst    = 1'b0;
   bit             recv_burst    = 1'b0;
   logic [7:0]     last_pixel    = 8'd128;
   window_result_type got_word, want_word;

   window_abs_diff_sum_3x3 u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_MAX) return LINE_MAX;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
   endfunction

   // slide the window by one pixel and queue the sum if the center is interior
   function automatic void predict_pixel(input logic [7:0] px);
      int unsigned    w, h, b, c, r, ci, sum;
      int             d;
      window_result_type res;
      w  = eff_width();
      h  = eff_height();
      b  = (border_reg == 0) ? 1 : border_reg;
      c  = col_pos;
      r  = row_pos;
      ci = c % LINE_MAX;
      for (int k = 0; k < 3; k++) begin
         win_cells[k*3]   = win_cells[k*3+1];
         win_cells[k*3+1] = win_cells[k*3+2];
      end
      win_cells[2]   = upper_line[ci];
      win_cells[5]   = lower_line[ci];
      win_cells[8]   = px;
      upper_line[ci] = lower_line[ci];
      lower_line[ci] = px;
      if (r >= b + 1 && c >= b + 1 && r + b <= h && c + b <= w) begin
         sum = 0;
         for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
               d   = int'(win_cells[k]) - int'(win_cells[4]);
               sum += (d < 0) ? -d : d;
            end
         end
         res.pad      = '0;
         res.col      = 10'(c - 1);
         res.row      = 12'(r - 1);
         res.response = 11'(sum);
         sums_due.push_back(res);
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic int unsigned pick_gap(input bit burst);
      int unsigned roll;
      if (burst) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] next_pixel(input pixel_style_type style);
      int v;
      case (style)
         PIX_EXTREME: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
         PIX_SMOOTH:  v = int'(last_pixel) + int'($urandom_range(0, 16)) - 8;
         PIX_FLAT:    v = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 255))
                                                       : int'(last_pixel);
         default:     v = $urandom_range(0, 255);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      last_pixel = v[7:0];
      return v[7:0];
   endfunction

   // pixel sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_pixel(req_tdata);
            pixels_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pixels_waiting.size() > 0) begin
               req_tdata  <= pixels_waiting.pop_front();
               req_tvalid <= 1'b1;
               send_gap = pick_gap(send_burst);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result receiver, with one long hold-off so the block backs up its input
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            stall_left = (words_seen == HOLD_AFTER) ? HOLD_CYCLES : pick_gap(recv_burst);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_word = rsp_tdata;
         if (sums_due.size() == 0) begin
            $error("result word with nothing expected: response %0d row %0d col %0d",
                   got_word.response, got_word.row, got_word.col);
            failures++;
         end else begin
            want_word = sums_due.pop_front();
            if (got_word.response !== want_word.response) begin
               $error("response: expected %0d, got %0d", want_word.response, got_word.response);
               failures++;
            end
            if (got_word.row !== want_word.row) begin
               $error("row: expected %0d, got %0d", want_word.row, got_word.row);
               failures++;
            end
            if (got_word.col !== want_word.col) begin
               $error("col: expected %0d, got %0d", want_word.col, got_word.col);
               failures++;
            end
            if (got_word.pad !== want_word.pad) begin
               $error("pad: expected %0h, got %0h", want_word.pad, got_word.pad);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** window_abs_diff_sum_3x3: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CSR_DW'(value);
      case (idx)
         REG_IMAGE_WIDTH:  width_reg  = 11'(value);
         REG_IMAGE_HEIGHT: height_reg = 13'(value);
         REG_BORDER:       border_reg = 4'(value);
         default: ;
      endcase
   endtask

   task automatic close_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic offer_pixel(input logic [7:0] value);
      pixels_waiting.push_back(value);
      pixels_queued++;
   endtask

   task automatic queue_pixels(input int unsigned n, input pixel_style_type style);
      for (int i = 0; i < n; i++) offer_pixel(next_pixel(style));
   endtask

   // all words taken, all results back, then a wait for the pipeline to drain
   task automatic settle();
      while (pixels_taken != pixels_queued) @(posedge clock);
      while (sums_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // one-pixel rows step the row counter cheaply; leaves col at 0
   task automatic seek_row(input int unsigned target);
      int unsigned h, steps;
      write_reg(REG_IMAGE_WIDTH, 0);
      close_writes();
      h = eff_height();
      if (row_pos >= h) steps = 1 + target;
      else if (target >= row_pos) steps = target - row_pos;
      else steps = h - row_pos + target;
      queue_pixels(steps, PIX_UNIFORM);
      settle();
   endtask

   initial begin
      int unsigned  random_items, n, sel;
      bit           wrote;
      pixel_style_type style;
      foreach (upper_line[i]) begin
         upper_line[i] = '0;
         lower_line[i] = '0;
      end
      foreach (win_cells[i]) win_cells[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      border_reg = BORDER_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // smallest frame: dark center in a bright ring, then the reverse
      write_reg(REG_IMAGE_WIDTH, 3);
      write_reg(REG_IMAGE_HEIGHT, 3);
      write_reg(REG_BORDER, 1);
      close_writes();
      for (int i = 0; i < 18; i++) begin
         offer_pixel(((i < 9) ? (i != 4) : (i == 13)) ? 8'd255 : 8'd0);
      end
      settle();

      // zero width and height: no interior at all
      write_reg(REG_IMAGE_WIDTH, 0);
      write_reg(REG_IMAGE_HEIGHT, 0);
      close_writes();
      queue_pixels(3, PIX_UNIFORM);
      settle();

      // wide row; the long receiver hold-off lands in here
      write_reg(REG_IMAGE_HEIGHT, 5);
      close_writes();
      send_burst = 1'b1;
      seek_row(2);
      write_reg(REG_IMAGE_WIDTH, WIDE_ROW);
      close_writes();
      queue_pixels(WIDE_ROW, PIX_UNIFORM);
      settle();

      // widest border
      write_reg(REG_IMAGE_HEIGHT, 40);
      write_reg(REG_BORDER, 15);
      close_writes();
      seek_row(16);
      write_reg(REG_IMAGE_WIDTH, 34);
      close_writes();
      send_burst = 1'b0;
      queue_pixels(68, PIX_EXTREME);
      settle();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         wrote = 1'b0;
         if ($urandom_range(0, 2) != 0) begin
            sel = $urandom_range(0, 19);
            write_reg(REG_IMAGE_WIDTH, (sel < 14)  ? $urandom_range(3, 16) :
                                       (sel < 17)  ? $urandom_range(17, 64) :
                                       (sel == 17) ? $urandom_range(0, 2) :
                                                     $urandom_range(1025, 2047));
            wrote = 1'b1;
         end
         if ($urandom_range(0, 2) != 0) begin
            sel = $urandom_range(0, 19);
            write_reg(REG_IMAGE_HEIGHT, (sel < 15)  ? $urandom_range(3, 10) :
                                        (sel < 17)  ? $urandom_range(0, 2) :
                                        (sel == 17) ? $urandom_range(4097, 8191) :
                                                      $urandom_range(11, 40));
            wrote = 1'b1;
         end
         if ($urandom_range(0, 2) != 0) begin
            sel = $urandom_range(0, 19);
            write_reg(REG_BORDER, (sel < 12)  ? 1 :
                                  (sel < 17)  ? $urandom_range(2, 3) :
                                  (sel == 17) ? 0 : $urandom_range(4, 15));
            wrote = 1'b1;
         end
         if (wrote) close_writes();
         send_burst = ($urandom_range(0, 4) == 0);
         recv_burst = ($urandom_range(0, 4) == 0);
         n     = $urandom_range(20, 90);
         style = pixel_style_type'($urandom_range(0, 3));
         queue_pixels(n, style);
         settle();
         random_items += n;
      end

      if (failures == 0) begin
         $display("** window_abs_diff_sum_3x3: PASSED **");
      end else begin
         $display("** window_abs_diff_sum_3x3: FAILED **");
      end
      $finish;
   end

endmodule

[window_abs_diff_sum_3x3.f]
rtl/core/wads3_pkg.sv
rtl/core/wads3_line_store.sv
rtl/core/window_abs_diff_sum_3x3.sv
rtl/core/wads3_check.sv
test/tb_window_abs_diff_sum_3x3.sv
